// ===== rtl/text_cell_buffer_engine_top_defines.svh =====
// Assertion helpers for the top RTL file; clock aclk, reset aresetn.
`ifndef TEXT_CELL_BUFFER_ENGINE_TOP_DEFINES_SVH
`define TEXT_CELL_BUFFER_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication.
`define TCBE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TCBE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcbe_pkg.sv =====
`default_nettype none
package tcbe_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int SHIFTED    = CELL_COUNT - COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COORD_W    = 8;
    localparam int LIN_W      = 2 * COORD_W + 1;
    localparam int CELL_W     = 16;
    localparam int CURSOR_W   = 16;

    localparam logic [7:0] BLANK_CODE = 8'h20;

    typedef enum logic [2:0] {
        OP_PUT    = 3'd0,
        OP_PEEK   = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_SCROLL = 3'd3,
        OP_CURSOR = 3'd4
    } tcbe_op_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] line;
        logic [7:0]         character;
        logic [7:0]         attribute;
    } tcbe_in_t;

    typedef struct packed {
        logic [CELL_W-1:0]   cell_value;
        logic [CURSOR_W-1:0] cursor_position;
        logic                out_of_range;
    } tcbe_out_t;

    typedef struct packed {
        logic                in_range;
        logic [ADDR_W-1:0]   cell_addr;
        logic [CURSOR_W-1:0] linear;
    } tcbe_loc_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] data;
    } tcbe_wr_t;

endpackage
`default_nettype wire

// ===== rtl/text_cell_buffer_engine_top.sv =====
`default_nettype none
// Text-mode cell store, 80 x 25 cells of 16 bits (attribute high, character low).
// s_ channel: one command beat (operation, column, line, character, attribute).
// m_ channel: exactly one result beat per command (cell_value, cursor_position,
// out_of_range), in command order.
// Result timing: put, set cursor, unknown codes, out-of-grid peek, clear and scroll
// register their result at accept, so it is valid in the cycle after accept; an
// in-grid peek is registered from ST_PEEK, where the synchronous cell RAM read returns.
// Throughput: put/cursor one command per cycle while m_ready drains each result;
// a peek holds s_ready low until its read returns; clear and scroll walk the cell
// RAM one cell per cycle through its single write port and hold s_ready low through
// ST_SWEEP and ST_FLUSH, so the next command is taken once the sweep is done.
// Scroll pipelines a read of cell i+80 with the write of the previous cell.
// Reset: after aresetn rises the block runs a clearing pass that zeroes every
// cell; s_ready stays low until it is done. Cursor resets to zero.
// A command is taken only while the result register is empty or being
// drained in the same cycle; a stalled m_ channel holds its beat and holds
// s_ready low for as long as m_ready stays low.
module text_cell_buffer_engine_top (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_valid,
    output logic                      s_ready,
    input  wire tcbe_pkg::tcbe_in_t   s_data,
    output logic                      m_valid,
    input  wire                       m_ready,
    output tcbe_pkg::tcbe_out_t       m_data
);
    import tcbe_pkg::*;
    `include "text_cell_buffer_engine_top_defines.svh"

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PEEK  = 4'b0010,
        ST_SWEEP = 4'b0100,
        ST_FLUSH = 4'b1000
    } tcbe_state_t;

    tcbe_state_t         state_reg, state_next;
    logic [ADDR_W-1:0]   cnt_reg, cnt_next;
    logic [CELL_W-1:0]   blank_reg, blank_next;
    logic                scroll_reg, scroll_next;
    logic                wr_pend_reg, wr_pend_next;
    logic                wr_move_reg, wr_move_next;
    logic [ADDR_W-1:0]   wr_addr_reg, wr_addr_next;
    logic [CURSOR_W-1:0] cursor_reg, cursor_next;
    logic                m_valid_reg, m_valid_next;
    tcbe_out_t           m_data_reg, m_data_next;

    tcbe_loc_t           loc;
    tcbe_wr_t            ram_wr;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [CELL_W-1:0]   rd_data;
    logic                accept;
    logic                slot_free;

    tcbe_addr_calc u_addr_calc (
        .column (s_data.column),
        .line   (s_data.line),
        .loc    (loc)
    );

    tcbe_cell_ram u_cell_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && slot_free;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        blank_next   = blank_reg;
        scroll_next  = scroll_reg;
        wr_pend_next = 1'b0;
        wr_move_next = 1'b0;
        wr_addr_next = wr_addr_reg;
        cursor_next  = cursor_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        rd_en        = 1'b0;
        rd_addr      = loc.cell_addr;

        // sweep writes own the port; puts only happen in idle
        ram_wr.en   = wr_pend_reg;
        ram_wr.addr = wr_addr_reg;
        ram_wr.data = wr_move_reg ? rd_data : blank_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_data_next.cell_value   = '0;
                    m_data_next.out_of_range = 1'b0;
                    m_valid_next             = 1'b1;
                    case (s_data.operation)
                        OP_PUT: begin
                            if (loc.in_range) begin
                                ram_wr.en   = 1'b1;
                                ram_wr.addr = loc.cell_addr;
                                ram_wr.data = {s_data.attribute, s_data.character};
                            end else begin
                                m_data_next.out_of_range = 1'b1;
                            end
                        end
                        OP_PEEK: begin
                            if (loc.in_range) begin
                                rd_en        = 1'b1;
                                m_valid_next = 1'b0;
                                state_next   = ST_PEEK;
                            end else begin
                                m_data_next.out_of_range = 1'b1;
                            end
                        end
                        OP_CLEAR, OP_SCROLL: begin
                            cnt_next    = '0;
                            blank_next  = {s_data.attribute, BLANK_CODE};
                            scroll_next = (s_data.operation == OP_SCROLL);
                            state_next  = ST_SWEEP;
                            if (s_data.operation == OP_CLEAR) begin
                                cursor_next = '0;
                            end
                        end
                        OP_CURSOR: begin
                            cursor_next = loc.linear;
                        end
                        default: begin
                        end
                    endcase
                    m_data_next.cursor_position = cursor_next;
                end
            end
            ST_PEEK: begin
                // slot was freed at accept; nothing else loads it meanwhile
                m_valid_next                = 1'b1;
                m_data_next.cell_value      = rd_data;
                m_data_next.cursor_position = cursor_reg;
                m_data_next.out_of_range    = 1'b0;
                state_next                  = ST_IDLE;
            end
            ST_SWEEP: begin
                rd_en        = scroll_reg && (cnt_reg < ADDR_W'(SHIFTED));
                rd_addr      = cnt_reg + ADDR_W'(COLUMNS);
                wr_pend_next = 1'b1;
                wr_move_next = rd_en;
                wr_addr_next = cnt_reg;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == ADDR_W'(CELL_COUNT - 1)) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                // last cell write goes out this cycle
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_SWEEP;
            cnt_reg     <= '0;
            blank_reg   <= '0;
            scroll_reg  <= 1'b0;
            wr_pend_reg <= 1'b0;
            wr_move_reg <= 1'b0;
            cursor_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            blank_reg   <= blank_next;
            scroll_reg  <= scroll_next;
            wr_pend_reg <= wr_pend_next;
            wr_move_reg <= wr_move_next;
            cursor_reg  <= cursor_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wr_addr_reg <= wr_addr_next;
        m_data_reg  <= m_data_next;
    end

    `TCBE_ASSERT_NXT(a_peek_waits_read, accept && s_data.operation == OP_PEEK && loc.in_range, !m_valid_reg && state_reg == ST_PEEK, "in-grid peek must wait one read cycle")
    `TCBE_ASSERT_NXT(a_peek_result, state_reg == ST_PEEK, m_valid_reg, "peek result not loaded")
    `TCBE_ASSERT_IMP(a_scroll_order, wr_pend_reg && rd_en && state_reg == ST_SWEEP, rd_addr > wr_addr_reg, "scroll write overtook its source read")
    `TCBE_ASSERT_NXT(a_cursor_hold, !accept, $stable(cursor_reg), "cursor changed without a command")
    `TCBE_ASSERT_IMP(a_no_put_in_sweep, state_reg != ST_IDLE, !accept, "command taken during a sweep or peek")

endmodule
`default_nettype wire

// ===== rtl/tcbe_cell_ram.sv =====
`default_nettype none
module tcbe_cell_ram (
    input  wire                          aclk,
    input  wire tcbe_pkg::tcbe_wr_t      wr,
    input  wire                          rd_en,
    input  wire  [tcbe_pkg::ADDR_W-1:0]  rd_addr,
    output logic [tcbe_pkg::CELL_W-1:0]  rd_data
);
    import tcbe_pkg::*;

    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic [CELL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== rtl/tcbe_addr_calc.sv =====
`default_nettype none
module tcbe_addr_calc (
    input  wire  [tcbe_pkg::COORD_W-1:0] column,
    input  wire  [tcbe_pkg::COORD_W-1:0] line,
    output tcbe_pkg::tcbe_loc_t          loc
);
    import tcbe_pkg::*;

    logic [LIN_W-1:0] linear_full;

    // row * COLUMNS + col; constant multiplier, 8 x 8 bits at most
    assign linear_full = LIN_W'(line) * LIN_W'(COLUMNS) + LIN_W'(column);

    always_comb begin
        loc.in_range  = ({1'b0, column} < (COORD_W + 1)'(COLUMNS)) &&
                        ({1'b0, line} < (COORD_W + 1)'(ROWS));
        loc.cell_addr = linear_full[ADDR_W-1:0];
        loc.linear    = linear_full[CURSOR_W-1:0];
    end

endmodule
`default_nettype wire

// ===== dv/text_cell_buffer_engine_top_tb.sv =====
`timescale 1ns / 100ps

module text_cell_buffer_engine_top_tb;
    import tcbe_pkg::*;

    // operation codes with no defined command
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    tcbe_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    tcbe_out_t m_data;

    // mirror of the cell store and cursor
    logic [CELL_W-1:0]   screen_cells [CELL_COUNT];
    logic [CURSOR_W-1:0] cursor_mirror;
    tcbe_out_t           awaited_results [$];
    tcbe_out_t           want;

    int err_count      = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;

    text_cell_buffer_engine_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #4 aclk = ~aclk;

    initial begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic tcbe_in_t make_cmd(logic [2:0] op, logic [7:0] col, logic [7:0] row,
                                          logic [7:0] ch, logic [7:0] attr);
        tcbe_in_t cmd;
        cmd.operation = op;
        cmd.column    = col;
        cmd.line      = row;
        cmd.character = ch;
        cmd.attribute = attr;
        return cmd;
    endfunction

    // Updates the mirror with one command and returns the result beat it should produce.
    function automatic tcbe_out_t compute_screen_result(tcbe_in_t cmd);
        tcbe_out_t res;
        logic      on_grid;
        int        addr;
        int        i;
        res     = '0;
        on_grid = (cmd.column < COLUMNS) && (cmd.line < ROWS);
        addr    = cmd.line * COLUMNS + cmd.column;
        case (cmd.operation)
            OP_PUT: begin
                if (on_grid) screen_cells[addr] = {cmd.attribute, cmd.character};
                else res.out_of_range = 1'b1;
            end
            OP_PEEK: begin
                if (on_grid) res.cell_value = screen_cells[addr];
                else res.out_of_range = 1'b1;
            end
            OP_CLEAR: begin
                for (i = 0; i < CELL_COUNT; i++) screen_cells[i] = {cmd.attribute, BLANK_CODE};
                cursor_mirror = '0;
            end
            OP_SCROLL: begin
                for (i = 0; i < SHIFTED; i++) screen_cells[i] = screen_cells[i + COLUMNS];
                for (i = SHIFTED; i < CELL_COUNT; i++)
                    screen_cells[i] = {cmd.attribute, BLANK_CODE};
            end
            OP_CURSOR: begin
                cursor_mirror = CURSOR_W'(cmd.line * COLUMNS + cmd.column);
            end
            default: ;
        endcase
        res.cursor_position = cursor_mirror;
        return res;
    endfunction

    // Coordinates biased toward a few hot spots so peeks hit written cells.
    function automatic tcbe_in_t random_command();
        tcbe_in_t cmd;
        int       pick;
        cmd  = make_cmd(OP_PUT, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        pick = $urandom_range(999);
        if (pick < 930) begin
            case ($urandom_range(3))
                0, 1: begin
                    cmd.column = 8'($urandom_range(7));
                    cmd.line   = 8'($urandom_range(3));
                end
                2: begin
                    cmd.column = 8'(COLUMNS - 1 - $urandom_range(3));
                    cmd.line   = 8'(ROWS - 1 - $urandom_range(3));
                end
                default: begin
                    cmd.column = 8'($urandom_range(COLUMNS - 1));
                    cmd.line   = 8'($urandom_range(ROWS - 1));
                end
            endcase
        end
        if (pick < 400)      cmd.operation = OP_PUT;
        else if (pick < 750) cmd.operation = OP_PEEK;
        else if (pick < 860) cmd.operation = OP_CURSOR;
        else if (pick < 880) cmd.operation = OP_CLEAR;
        else if (pick < 900) cmd.operation = OP_SCROLL;
        else if (pick < 930) cmd.operation = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        else begin
            // off-grid put or peek; raw coordinates, forced out on one axis
            cmd.operation = $urandom_range(1) ? OP_PUT : OP_PEEK;
            if ($urandom_range(1)) cmd.column = 8'($urandom_range(255, COLUMNS));
            else cmd.line = 8'($urandom_range(255, ROWS));
        end
        return cmd;
    endfunction

    // Called right after a falling edge; returns right after the falling edge that follows acceptance of the command.
    task automatic send_cmd(tcbe_in_t cmd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= cmd;
        do @(posedge aclk); while (!s_ready);
        awaited_results.push_back(compute_screen_result(cmd));
        @(negedge aclk);
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result beat with no command outstanding");
                err_count++;
            end else begin
                want = awaited_results.pop_front();
                if (m_data.cell_value !== want.cell_value) begin
                    $error("cell_value: expected %h, got %h", want.cell_value,
                           m_data.cell_value);
                    err_count++;
                end
                if (m_data.cursor_position !== want.cursor_position) begin
                    $error("cursor_position: expected %h, got %h", want.cursor_position,
                           m_data.cursor_position);
                    err_count++;
                end
                if (m_data.out_of_range !== want.out_of_range) begin
                    $error("out_of_range: expected %b, got %b", want.out_of_range,
                           m_data.out_of_range);
                    err_count++;
                end
            end
        end
    end

    task automatic test_reset_contents();
        send_cmd(make_cmd(OP_PEEK, 8'd0, 8'd0, 8'h00, 8'h00));
        send_cmd(make_cmd(OP_PEEK, 8'(COLUMNS - 1), 8'(ROWS - 1), 8'hFF, 8'hFF));
    endtask

    task automatic test_corner_cells();
        send_cmd(make_cmd(OP_PUT, 8'd0, 8'd0, 8'hFF, 8'h00));
        send_cmd(make_cmd(OP_PUT, 8'(COLUMNS - 1), 8'(ROWS - 1), 8'h00, 8'hFF));
        send_cmd(make_cmd(OP_PEEK, 8'd0, 8'd0, 8'h00, 8'h00));
        send_cmd(make_cmd(OP_PEEK, 8'(COLUMNS - 1), 8'(ROWS - 1), 8'h00, 8'h00));
    endtask

    task automatic test_off_grid();
        send_cmd(make_cmd(OP_PUT, 8'(COLUMNS), 8'd0, 8'h41, 8'h0F));
        send_cmd(make_cmd(OP_PUT, 8'd0, 8'(ROWS), 8'h42, 8'h0E));
        send_cmd(make_cmd(OP_PEEK, 8'hFF, 8'hFF, 8'h00, 8'h00));
        send_cmd(make_cmd(OP_PEEK, 8'(COLUMNS - 1), 8'(ROWS), 8'h00, 8'h00));
    endtask

    task automatic test_cursor_set();
        send_cmd(make_cmd(OP_CURSOR, 8'hFF, 8'hFF, 8'h00, 8'h00));
        send_cmd(make_cmd(OP_CURSOR, 8'(COLUMNS - 1), 8'(ROWS - 1), 8'hFF, 8'hFF));
    endtask

    task automatic test_unused_codes();
        send_cmd(make_cmd(OP_UNUSED_LO, 8'd0, 8'd0, 8'h55, 8'hAA));
        send_cmd(make_cmd(OP_UNUSED_LO + 3'd1, 8'd3, 8'd3, 8'hAA, 8'h55));
        send_cmd(make_cmd(OP_UNUSED_HI, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    endtask

    task automatic test_scroll_up();
        send_cmd(make_cmd(OP_SCROLL, 8'd0, 8'd0, 8'h00, 8'hA5));
        send_cmd(make_cmd(OP_PEEK, 8'(COLUMNS - 1), 8'(ROWS - 2), 8'h00, 8'h00));
        send_cmd(make_cmd(OP_PEEK, 8'(COLUMNS - 1), 8'(ROWS - 1), 8'h00, 8'h00));
    endtask

    task automatic test_clear_screen();
        send_cmd(make_cmd(OP_CLEAR, 8'h12, 8'h34, 8'h56, 8'hFF));
        send_cmd(make_cmd(OP_PEEK, 8'd40, 8'd12, 8'h00, 8'h00));
    endtask

    task automatic test_random_traffic(int count, int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) send_cmd(random_command());
    endtask

    // long m_ready hold while commands keep coming: block must back up and stall s_ready
    task automatic test_full_stall();
        tcbe_in_t cmd;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 300;
        repeat (40) begin
            cmd = random_command();
            while (cmd.operation == OP_CLEAR || cmd.operation == OP_SCROLL)
                cmd = random_command();
            send_cmd(cmd);
        end
    endtask

    task automatic test_drained_restart();
        send_idle_pct  = 0;
        recv_stall_pct = 20;
        repeat (15) send_cmd(random_command());
        wait_results_drained();
        repeat (15) send_cmd(random_command());
    endtask

    initial begin
        foreach (screen_cells[i]) screen_cells[i] = '0;
        cursor_mirror = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_contents();
        test_corner_cells();
        test_off_grid();
        test_cursor_set();
        test_unused_codes();
        test_scroll_up();
        test_clear_screen();
        test_random_traffic(500, 36, 64);
        test_random_traffic(500, 64, 36);
        test_random_traffic(500, 0, 0);
        test_full_stall();
        test_drained_restart();

        recv_stall_pct = 0;
        wait_results_drained();
        repeat (20) @(posedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tcbe_pkg.sv
rtl/tcbe_cell_ram.sv
rtl/tcbe_addr_calc.sv
rtl/text_cell_buffer_engine_top.sv
dv/text_cell_buffer_engine_top_tb.sv
